/* rtl/ssc_pkg.sv */
// ============================================================================
// ssc_pkg: shared types for the sphere-sphere contact block
// Coordinate width and the packed operand and result words of the ports.
// ============================================================================
package ssc_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int RADIUS_WIDTH = 31;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [RADIUS_WIDTH-1:0]       radius_t;

    typedef struct packed {
        coord_t  first_center_x;
        coord_t  first_center_y;
        coord_t  first_center_z;
        coord_t  second_center_x;
        coord_t  second_center_y;
        coord_t  second_center_z;
        radius_t first_radius;
        radius_t second_radius;
    } operand_t;

    typedef struct packed {
        logic   hit;
        coord_t first_contact_x;
        coord_t first_contact_y;
        coord_t first_contact_z;
        coord_t second_contact_x;
        coord_t second_contact_y;
        coord_t second_contact_z;
    } result_t;

endpackage

/* rtl/sphere_sphere_contact.sv */
// ============================================================================
// sphere_sphere_contact: overlap test and contact points of two spheres
// Squared distance against squared radius sum, then a pipelined square root
// and six pipelined dividers give the surface point on each sphere.
// ============================================================================
// Throughput: one word per cycle; busy is always low and nothing stalls.
// The depth is set by the square root (32 stages, one root bit each) and the
// restoring dividers (31 stages, one quotient bit each).
// Reset: rst_n clears all valid bits at once; data registers are not reset.
// The receiver takes every result in its strobe cycle and cannot hold it off.
module sphere_sphere_contact
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssc_pkg::operand_t operands,
    output logic              done,
    output ssc_pkg::result_t  result
);

    localparam int W        = ssc_pkg::COORD_WIDTH;
    localparam int RW       = ssc_pkg::RADIUS_WIDTH;
    localparam int SQ_STEPS = 32;          // root bits of a 64-bit radicand
    localparam int QB       = RW;          // quotient bits: q <= radius
    localparam int PW       = 32 + RW;     // |d| * radius
    localparam int LATENCY  = SQ_STEPS + QB + 4;

    localparam logic signed [W+1:0] SAT_HI = (W+2)'((64'(1) << (W - 1)) - 64'(1));
    localparam logic signed [W+1:0] SAT_LO = -SAT_HI - (W+2)'(1);

    // sideband through the root stages
    typedef struct packed {
        logic                          hit;
        logic [2:0][W-1:0]             c0;
        logic [2:0][W-1:0]             c1;
        logic [2:0]                    neg;
        logic [2:0][31:0]              ad;
        logic [RW-1:0]                 r0;
        logic [RW-1:0]                 r1;
    } side_t;

    // sideband through the divider stages
    typedef struct packed {
        logic                          hit;
        logic                          dzero;
        logic [2:0][W-1:0]             c0;
        logic [2:0][W-1:0]             c1;
        logic [2:0]                    neg;
    } dside_t;

    assign busy = 1'b0;

    wire accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: differences, magnitudes, radius sum, per-axis reject
    // ------------------------------------------------------------------
    logic        v1_reg;
    side_t       side1_reg, side1_next;
    logic [31:0] rs1_reg, rs1_next;

    always_comb
    begin
        logic [2:0][W-1:0] c0;
        logic [2:0][W-1:0] c1;
        logic signed [W:0] d;
        logic [W:0]        mag;
        c0[0] = operands.first_center_x;
        c0[1] = operands.first_center_y;
        c0[2] = operands.first_center_z;
        c1[0] = operands.second_center_x;
        c1[1] = operands.second_center_y;
        c1[2] = operands.second_center_z;
        rs1_next      = 32'(operands.first_radius) + 32'(operands.second_radius);
        side1_next.c0 = c0;
        side1_next.c1 = c1;
        side1_next.r0 = operands.first_radius;
        side1_next.r1 = operands.second_radius;
        side1_next.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            d   = $signed({c1[i][W-1], c1[i]}) - $signed({c0[i][W-1], c0[i]});
            mag = d[W] ? (W+1)'(-d) : (W+1)'(d);
            side1_next.neg[i] = d[W];
            side1_next.ad[i]  = 32'(mag);
            if (64'(mag) >= 64'(rs1_next))
            begin
                side1_next.hit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side1_next;
        rs1_reg   <= rs1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: squares
    // ------------------------------------------------------------------
    logic             v2_reg;
    side_t            side2_reg;
    logic [2:0][63:0] sq2_reg, sq2_next;
    logic [63:0]      rs2_reg, rs2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_next[i] = 64'(side1_reg.ad[i]) * 64'(side1_reg.ad[i]);
        end
        rs2_next = 64'(rs1_reg) * 64'(rs1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side1_reg;
        sq2_reg   <= sq2_next;
        rs2_reg   <= rs2_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance and overlap; feeds root stage 0
    // ------------------------------------------------------------------
    logic        sqv_reg   [0:SQ_STEPS];
    logic [63:0] sqx_reg   [0:SQ_STEPS];
    logic [63:0] sqres_reg [0:SQ_STEPS];
    side_t       sside_reg [0:SQ_STEPS];

    logic [65:0] d2_next;
    side_t       side3_next;

    always_comb
    begin
        d2_next = 66'(sq2_reg[0]) + 66'(sq2_reg[1]) + 66'(sq2_reg[2]);
        side3_next = side2_reg;
        side3_next.hit = side2_reg.hit && (d2_next < 66'(rs2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqv_reg[0] <= 1'b0;
        end
        else
        begin
            sqv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg[0]   <= 64'(d2_next);
        sqres_reg[0] <= 64'd0;
        sside_reg[0] <= side3_next;
    end

    // ------------------------------------------------------------------
    // Root stages: one result bit per stage, bit weight 4^(31-k)
    // ------------------------------------------------------------------
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BITW = 64'(1) << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] x_next;
        logic [63:0] res_next;

        always_comb
        begin
            trial = sqres_reg[k] + BITW;
            if (sqx_reg[k] >= trial)
            begin
                x_next   = sqx_reg[k] - trial;
                res_next = (sqres_reg[k] >> 1) + BITW;
            end
            else
            begin
                x_next   = sqx_reg[k];
                res_next = sqres_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqv_reg[k+1] <= 1'b0;
            end
            else
            begin
                sqv_reg[k+1] <= sqv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sqx_reg[k+1]   <= x_next;
            sqres_reg[k+1] <= res_next;
            sside_reg[k+1] <= sside_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Product stage: |d_i| * radius for six lanes; feeds divider stage 0
    // lanes 0..2 use the first radius, lanes 3..5 the second
    // ------------------------------------------------------------------
    logic                 dv_reg    [0:QB];
    logic [31:0]          dist_reg  [0:QB];
    logic [5:0][PW-1:0]   rem_reg   [0:QB];
    logic [5:0][QB-1:0]   quo_reg   [0:QB];
    dside_t               dside_reg [0:QB];

    logic [5:0][PW-1:0] prod_next;
    dside_t             dside_next;
    logic [31:0]        dist_next;

    always_comb
    begin
        dist_next = sqres_reg[SQ_STEPS][31:0];
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i]     = PW'(sside_reg[SQ_STEPS].ad[i]) * PW'(sside_reg[SQ_STEPS].r0);
            prod_next[i + 3] = PW'(sside_reg[SQ_STEPS].ad[i]) * PW'(sside_reg[SQ_STEPS].r1);
        end
        dside_next.hit   = sside_reg[SQ_STEPS].hit;
        dside_next.dzero = (dist_next == 32'd0);
        dside_next.c0    = sside_reg[SQ_STEPS].c0;
        dside_next.c1    = sside_reg[SQ_STEPS].c1;
        dside_next.neg   = sside_reg[SQ_STEPS].neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= sqv_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg[0]  <= dist_next;
        rem_reg[0]   <= prod_next;
        quo_reg[0]   <= '0;
        dside_reg[0] <= dside_next;
    end

    // ------------------------------------------------------------------
    // Divider stages: restoring, quotient bit (QB-1-j) at stage j
    // ------------------------------------------------------------------
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int SH = QB - 1 - j;
        logic [PW-1:0]      dsh;
        logic [5:0][PW-1:0] rem_next;
        logic [5:0][QB-1:0] quo_next;

        always_comb
        begin
            dsh      = PW'(dist_reg[j]) << SH;
            rem_next = rem_reg[j];
            quo_next = quo_reg[j];
            for (int l = 0; l < 6; l++)
            begin
                if (rem_reg[j][l] >= dsh)
                begin
                    rem_next[l]     = rem_reg[j][l] - dsh;
                    quo_next[l][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dist_reg[j+1]  <= dist_reg[j];
            rem_reg[j+1]   <= rem_next;
            quo_reg[j+1]   <= quo_next;
            dside_reg[j+1] <= dside_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: signed offsets, saturating add, miss gives zeros
    // ------------------------------------------------------------------
    logic             done_reg;
    ssc_pkg::result_t result_reg, result_next;

    function automatic logic [W-1:0] sat(input logic signed [W+1:0] v);
        logic [W-1:0] r;
        if (v > SAT_HI)
        begin
            r = W'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = W'(SAT_LO);
        end
        else
        begin
            r = W'(v);
        end
        return r;
    endfunction

    always_comb
    begin
        dside_t            ds;
        logic [2:0][W-1:0] c0o;
        logic [2:0][W-1:0] c1o;
        logic signed [W+1:0] o0;
        logic signed [W+1:0] o1;
        ds = dside_reg[QB];
        for (int i = 0; i < 3; i++)
        begin
            o0 = $signed((W+2)'(quo_reg[QB][i]));
            o1 = $signed((W+2)'(quo_reg[QB][i + 3]));
            if (ds.dzero)
            begin
                o0 = '0;
                o1 = '0;
            end
            if (ds.neg[i])
            begin
                o0 = -o0;
                o1 = -o1;
            end
            c0o[i] = sat($signed({{2{ds.c0[i][W-1]}}, ds.c0[i]}) + o0);
            c1o[i] = sat($signed({{2{ds.c1[i][W-1]}}, ds.c1[i]}) - o1);
            if (!ds.hit)
            begin
                c0o[i] = '0;
                c1o[i] = '0;
            end
        end
        result_next.hit              = ds.hit;
        result_next.first_contact_x  = c0o[0];
        result_next.first_contact_y  = c0o[1];
        result_next.first_contact_z  = c0o[2];
        result_next.second_contact_x = c1o[0];
        result_next.second_contact_y = c1o[1];
        result_next.second_contact_z = c1o[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every accepted word comes out after the full pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY + 1) done)
        else $error("result strobe missing after pipeline depth");

    // root remainder bound: d2 - root^2 <= 2*root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sqv_reg[SQ_STEPS] |->
            (65'(sqx_reg[SQ_STEPS]) <= (65'(sqres_reg[SQ_STEPS]) << 1)))
        else $error("square root remainder out of range");

    // a miss carries zero contacts
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |->
            (result.first_contact_x == '0 && result.second_contact_x == '0 &&
             result.first_contact_y == '0 && result.second_contact_y == '0 &&
             result.first_contact_z == '0 && result.second_contact_z == '0))
        else $error("miss with nonzero contact");

endmodule
